### rtl/lfo_multiwave_with_lfsr_noise_assert.svh
// assertion macros shared by the lfo rtl
`ifndef LFO_MULTIWAVE_WITH_LFSR_NOISE_ASSERT_SVH
`define LFO_MULTIWAVE_WITH_LFSR_NOISE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LFO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfo assertion failed");

// next-cycle implication, checked out of reset
`define LFO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfo assertion failed");

`endif

### rtl/lfo_pkg.sv
// package: types, constants and helpers for the lfo
package lfo_pkg;

  localparam int PHASE_FRACTION_BITS = 14;
  localparam int IDX_W = 16;
  localparam int ACC_W = IDX_W + PHASE_FRACTION_BITS;
  localparam int SAMPLE_W = 16;
  localparam int PULSE_W = 17;
  localparam int NOISE_W = 23;
  localparam int NOISE_TAP = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int WAVE_W = 3;

  localparam logic [NOISE_W-1:0] NOISE_RESET = 23'h7ffff8;
  localparam int PHASE_STEP_RESET = 1217;
  localparam logic [PULSE_W-1:0] PULSE_RESET = 17'd32768;

  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [13:0] SIN_B = 14'd10583;
  localparam logic [10:0] SIN_C = 11'd1306;

  typedef enum logic [WAVE_W-1:0] {
    SHAPE_RAMP     = 3'd0,
    SHAPE_SQUARE   = 3'd1,
    SHAPE_TRIANGLE = 3'd2,
    SHAPE_SINUS    = 3'd3,
    SHAPE_NOISE    = 3'd4
  } wave_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_PULSE_WIDTH = 2'd1,
    REG_WAVE_SELECT = 2'd2,
    REG_RETRIGGER   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WAVE_W-1:0] wave;
    logic [IDX_W-1:0]  idx;
    logic              pulse_low;
    logic [7:0]        noise;
  } shape_word_t;

  function automatic logic [7:0] noise_tap(input logic [NOISE_W-1:0] sr);
    logic [7:0] v;
    v = {sr[22], sr[20], sr[16], sr[13], sr[11], sr[7], sr[4], sr[2]};
    return v;
  endfunction

endpackage

### rtl/lfo_if.sv
// handshake interfaces for trigger, sample and configuration channels
interface lfo_trig_if;
  logic valid;
  logic ready;
  logic note_trigger;
  modport source (output valid, output note_trigger, input ready);
  modport sink (input valid, input note_trigger, output ready);
endinterface

interface lfo_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [lfo_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface lfo_cfg_if #(parameter int DATA_W = lfo_pkg::ACC_W);
  logic                            valid;
  logic                            ready;
  logic [lfo_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [DATA_W-1:0]               data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

### rtl/lfo_shape.sv
// waveform shaping pipeline: five stages from phase word to output sample
module lfo_shape (
  input  logic                 clk,
  input  logic                 rst,
  input  lfo_pkg::shape_word_t word_in,
  input  logic                 word_valid,
  output logic                 word_ready,
  lfo_sample_if.source         wave_out
);

  logic v1, v2, v3, v4, v5;
  logic ld1, ld2, ld3, ld4, ld5;

  logic        s1_sine, s2_sine, s3_sine, s4_sine;
  logic        s1_neg, s2_neg, s3_neg, s4_neg;
  logic [15:0] s1_other, s2_other, s3_other, s4_other;
  logic [14:0] s1_u, s2_u, s3_u;
  logic [14:0] s1_u2, s2_u2;
  logic [10:0] s2_p1;
  logic [13:0] s3_p2;
  logic [14:0] s4_p3;
  logic [15:0] s5_sample;

  logic [15:0] other_next;
  logic [14:0] u_next;
  logic [29:0] usq;
  logic [25:0] prod1;
  logic [13:0] t1;
  logic [28:0] prod2;
  logic [14:0] t2;
  logic [29:0] prod3;
  logic [15:0] ysat;
  logic [15:0] sample_next;

  always_comb begin
    ld5 = !v5 || wave_out.ready;
    ld4 = !v4 || ld5;
    ld3 = !v3 || ld4;
    ld2 = !v2 || ld3;
    ld1 = !v1 || ld2;
    word_ready = ld1;
  end

  // stage 1: non-sine waves and sine fold plus square
  always_comb begin
    case (lfo_pkg::wave_t'(word_in.wave))
      lfo_pkg::SHAPE_RAMP: begin
        other_next = word_in.idx ^ 16'h8000;
      end
      lfo_pkg::SHAPE_SQUARE: begin
        other_next = word_in.pulse_low ? 16'h8000 : 16'h7fff;
      end
      lfo_pkg::SHAPE_TRIANGLE: begin
        other_next = (word_in.idx[15] ? ~{word_in.idx[14:0], 1'b0}
                                      : {word_in.idx[14:0], 1'b0}) ^ 16'h8000;
      end
      default: begin
        other_next = {word_in.noise, 8'h00} ^ 16'h8000;
      end
    endcase
    u_next = word_in.idx[14] ? (15'h4000 - {1'b0, word_in.idx[13:0]})
                             : {1'b0, word_in.idx[13:0]};
    usq = 30'(u_next) * 30'(u_next);
  end

  // stages 2 to 4: polynomial terms, one product each
  always_comb begin
    prod1 = 26'(s1_u2) * 26'(lfo_pkg::SIN_C);
    t1    = lfo_pkg::SIN_B - {3'b000, s2_p1};
    prod2 = 29'(s2_u2) * 29'(t1);
    t2    = lfo_pkg::SIN_A - {1'b0, s3_p2};
    prod3 = 30'(s3_u) * 30'(t2);
  end

  // stage 5: scale, clamp, sign
  always_comb begin
    ysat = s4_p3[14] ? 16'h7fff : {s4_p3, 1'b0};
    if (s4_sine) begin
      sample_next = s4_neg ? (16'h0000 - ysat) : ysat;
    end else begin
      sample_next = s4_other;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ld1) v1 <= word_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_sine  <= (word_in.wave == lfo_pkg::SHAPE_SINUS);
      s1_neg   <= word_in.idx[15];
      s1_other <= other_next;
      s1_u     <= u_next;
      s1_u2    <= usq[28:14];
    end
    if (ld2) begin
      s2_sine  <= s1_sine;
      s2_neg   <= s1_neg;
      s2_other <= s1_other;
      s2_u     <= s1_u;
      s2_u2    <= s1_u2;
      s2_p1    <= prod1[24:14];
    end
    if (ld3) begin
      s3_sine  <= s2_sine;
      s3_neg   <= s2_neg;
      s3_other <= s2_other;
      s3_u     <= s2_u;
      s3_p2    <= prod2[27:14];
    end
    if (ld4) begin
      s4_sine  <= s3_sine;
      s4_neg   <= s3_neg;
      s4_other <= s3_other;
      s4_p3    <= prod3[28:14];
    end
    if (ld5) begin
      s5_sample <= sample_next;
    end
  end

  assign wave_out.valid  = v5;
  assign wave_out.sample = s5_sample;

`include "lfo_multiwave_with_lfsr_noise_assert.svh"

  `LFO_ASSERT_IMP(a_fill_order, $rose(v5), $past(v4))
  `LFO_ASSERT_IMP(a_sine_range, v4, s4_p3 <= lfo_pkg::SIN_A)
  `LFO_ASSERT_IMP(a_no_drop, !word_ready, v1 && v2 && v3 && v4 && v5)

endmodule

### rtl/lfo_multiwave_with_lfsr_noise.sv
// top level: phase accumulator, noise shift register, config and shaping pipeline
// path: an accepted trigger word passes the word register, then shaping stages 1 to 5, to the output
// throughput: one word per cycle; ready drops only when all six stage registers
//   hold words and the output is stalled; the sine path's chained products set the depth
// reset (synchronous, rst high): phase cleared, noise register 0x7ffff8,
//   registers to reset values, pipeline empty
module lfo_multiwave_with_lfsr_noise (
  input  logic          clk,
  input  logic          rst,
  lfo_trig_if.sink      trig,
  lfo_sample_if.source  wave_out,
  lfo_cfg_if.sink       cfg
);

  localparam int ACC_W = lfo_pkg::ACC_W;

  logic [ACC_W-1:0]             phase_step;
  logic [lfo_pkg::PULSE_W-1:0]  pulse_width;
  logic [lfo_pkg::WAVE_W-1:0]   wave_select;
  logic                         retrigger_enable;

  logic [ACC_W-1:0]             phase_accum;
  logic [ACC_W-1:0]             phase_base;
  logic [ACC_W:0]               phase_sum;
  logic [lfo_pkg::NOISE_W-1:0]  noise_shift;
  logic [lfo_pkg::NOISE_W-1:0]  noise_base;
  logic [lfo_pkg::NOISE_W-1:0]  noise_shift_next;
  logic [lfo_pkg::IDX_W-1:0]    idx;

  logic                         restart;
  logic                         in_accept;
  logic                         stage_ready;
  logic                         shape_ready;
  logic                         word_valid;
  lfo_pkg::shape_word_t         word;
  lfo_pkg::shape_word_t         word_next;

  always_comb begin
    restart    = trig.note_trigger && retrigger_enable;
    phase_base = restart ? '0 : phase_accum;
    noise_base = restart ? lfo_pkg::NOISE_RESET : noise_shift;
    idx        = phase_base[ACC_W-1 -: lfo_pkg::IDX_W];
    phase_sum  = {1'b0, phase_base} + {1'b0, phase_step};
    // carry out of the accumulator clocks the noise register
    if (phase_sum[ACC_W]) begin
      noise_shift_next = {noise_base[lfo_pkg::NOISE_W-2:0],
                          noise_base[lfo_pkg::NOISE_W-1] ^ noise_base[lfo_pkg::NOISE_TAP]};
    end else begin
      noise_shift_next = noise_base;
    end
    word_next.wave      = wave_select;
    word_next.idx       = idx;
    word_next.pulse_low = ({1'b0, idx} < pulse_width);
    word_next.noise     = lfo_pkg::noise_tap(noise_base);
  end

  assign stage_ready = !word_valid || shape_ready;
  assign trig.ready  = stage_ready;
  assign in_accept   = trig.valid && stage_ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= ACC_W'(lfo_pkg::PHASE_STEP_RESET);
      pulse_width      <= lfo_pkg::PULSE_RESET;
      wave_select      <= lfo_pkg::SHAPE_RAMP;
      retrigger_enable <= 1'b0;
      phase_accum      <= '0;
      noise_shift      <= lfo_pkg::NOISE_RESET;
      word_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (lfo_pkg::cfg_reg_t'(cfg.reg_index))
          lfo_pkg::REG_PHASE_STEP: begin
            phase_step <= cfg.data;
          end
          lfo_pkg::REG_PULSE_WIDTH: begin
            pulse_width <= cfg.data[lfo_pkg::PULSE_W-1:0];
          end
          lfo_pkg::REG_WAVE_SELECT: begin
            wave_select <= cfg.data[lfo_pkg::WAVE_W-1:0];
          end
          lfo_pkg::REG_RETRIGGER: begin
            retrigger_enable <= cfg.data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        phase_accum <= phase_sum[ACC_W-1:0];
        noise_shift <= noise_shift_next;
      end
      if (stage_ready) begin
        word_valid <= trig.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready) begin
      word <= word_next;
    end
  end

  lfo_shape u_shape (
    .clk        (clk),
    .rst        (rst),
    .word_in    (word),
    .word_valid (word_valid),
    .word_ready (shape_ready),
    .wave_out   (wave_out)
  );

`include "lfo_multiwave_with_lfsr_noise_assert.svh"

  `LFO_ASSERT_NXT(a_retrig_phase, in_accept && restart, phase_accum == $past(phase_step))
  `LFO_ASSERT_IMP(a_noise_live, 1'b1, noise_shift != '0)
  `LFO_ASSERT_NXT(a_hold_idle, !in_accept, $stable(phase_accum) && $stable(noise_shift))

endmodule

### bench/testbench.sv
// self-checking bench for the lfo: directed table, random phases, sample predictor
`timescale 1ns / 100ps

module testbench;

  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_WORDS = 700;

  typedef struct packed {
    logic              is_cfg;
    lfo_pkg::cfg_reg_t reg_sel;
    logic [29:0]       value;
    logic              trig;
    logic              known;
    logic [15:0]       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  lfo_trig_if trig_ch ();
  lfo_sample_if sample_ch ();
  lfo_cfg_if #(.DATA_W(30)) cfg_ch ();

  lfo_multiwave_with_lfsr_noise i_dut (
    .clk      (clk),
    .rst      (rst),
    .trig     (trig_ch),
    .wave_out (sample_ch),
    .cfg      (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // oscillator settings and state as seen by the predictor
  logic [29:0] step_q = 30'(lfo_pkg::PHASE_STEP_RESET);
  logic [16:0] width_q = lfo_pkg::PULSE_RESET;
  logic [2:0]  wave_q = lfo_pkg::SHAPE_RAMP;
  logic        retrig_q = 1'b0;
  logic [29:0] acc_q = '0;
  logic [22:0] lfsr_q = lfo_pkg::NOISE_RESET;

  logic [15:0] pending_samples[$];
  stim_row_t   stim_table[$];
  int          fail_count = 0;
  int          words_sent = 0;
  bit          hold_req = 1'b0;

  function automatic logic [15:0] lfo_tick(input logic trig);
    logic [15:0] idx;
    logic [15:0] s;
    logic [16:0] tri_v;
    logic [31:0] u, u2, t1, t2, y;
    logic [30:0] sum;
    if (trig && retrig_q) begin
      acc_q = '0;
      lfsr_q = lfo_pkg::NOISE_RESET;
    end
    idx = acc_q[29:14];
    case (wave_q)
      lfo_pkg::SHAPE_RAMP: s = idx ^ 16'h8000;
      lfo_pkg::SHAPE_SQUARE: s = ({1'b0, idx} < width_q) ? 16'h8000 : 16'h7fff;
      lfo_pkg::SHAPE_TRIANGLE: begin
        tri_v = idx[15] ? 17'd131071 - {idx, 1'b0} : {idx, 1'b0};
        s = tri_v[15:0] ^ 16'h8000;
      end
      lfo_pkg::SHAPE_SINUS: begin
        u = idx[14] ? 32'h4000 - {18'd0, idx[13:0]} : {18'd0, idx[13:0]};
        u2 = (u * u) >> 14;
        t1 = 32'd10583 - ((u2 * 32'd1306) >> 14);
        t2 = 32'd25736 - ((u2 * t1) >> 14);
        y = ((u * t2) >> 14) * 2;
        if (y > 32'd32767) y = 32'd32767;
        s = idx[15] ? 16'h0000 - y[15:0] : y[15:0];
      end
      default: begin
        s = {lfsr_q[22], lfsr_q[20], lfsr_q[16], lfsr_q[13],
             lfsr_q[11], lfsr_q[7], lfsr_q[4], lfsr_q[2], 8'h00} ^ 16'h8000;
      end
    endcase
    sum = {1'b0, acc_q} + {1'b0, step_q};
    if (sum[30]) lfsr_q = {lfsr_q[21:0], lfsr_q[22] ^ lfsr_q[17]};
    acc_q = sum[29:0];
    return s;
  endfunction

  function automatic void row_cfg(input lfo_pkg::cfg_reg_t sel, input logic [29:0] value);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.value = value;
    stim_table.push_back(r);
  endfunction

  function automatic void row_word(input logic trig, input logic known,
                                   input logic [15:0] want);
    stim_row_t r;
    r = '0;
    r.trig = trig;
    r.known = known;
    r.want = want;
    stim_table.push_back(r);
  endfunction

  task automatic flag_failure(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  task automatic write_reg(input lfo_pkg::cfg_reg_t sel, input logic [29:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= sel;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (sel)
      lfo_pkg::REG_PHASE_STEP:  step_q = value;
      lfo_pkg::REG_PULSE_WIDTH: width_q = value[16:0];
      lfo_pkg::REG_WAVE_SELECT: wave_q = value[2:0];
      lfo_pkg::REG_RETRIGGER:   retrig_q = value[0];
      default: ;
    endcase
  endtask

  task automatic send_trigger(input logic trig, input logic known, input logic [15:0] want);
    logic [15:0] predicted;
    trig_ch.valid <= 1'b1;
    trig_ch.note_trigger <= trig;
    do @(posedge clk); while (!trig_ch.ready);
    predicted = lfo_tick(trig);
    pending_samples.push_back(known ? want : predicted);
    words_sent++;
  endtask

  task automatic drain();
    trig_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic send_words(input int n, input bit gapless);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = gapless ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          trig_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_trigger($urandom_range(0, 7) == 0, 1'b0, 16'h0000);
      burst_left--;
    end
  endtask

  task automatic random_setup();
    logic [29:0] v;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0: v = 30'd1;
        1: v = 30'h3fffffff;
        2: v = 30'($urandom_range(1, 4095));
        3: v = 30'd1 << $urandom_range(0, 29);
        default: begin
          v = 30'($urandom);
          if (v == 0) v = 30'd1;
        end
      endcase
      write_reg(lfo_pkg::REG_PHASE_STEP, v);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: v = 30'd0;
        1: v = 30'd65536;
        2: v = 30'($urandom_range(0, 65536));
        default: v = 30'($urandom);
      endcase
      write_reg(lfo_pkg::REG_PULSE_WIDTH, v);
    end
    if ($urandom_range(0, 1)) write_reg(lfo_pkg::REG_WAVE_SELECT, 30'($urandom));
    if ($urandom_range(0, 1)) write_reg(lfo_pkg::REG_RETRIGGER, 30'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // sample sink: own stall pattern, plus one long hold-off on request
  initial begin
    int hold_left;
    int pat_age;
    bit hold_seen;
    logic [15:0] stall_bits;
    hold_left = 0;
    pat_age = 0;
    hold_seen = 1'b0;
    stall_bits = '1;
    sample_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        sample_ch.ready <= 1'b0;
      end else if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
        sample_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        sample_ch.ready <= 1'b0;
      end else begin
        sample_ch.ready <= stall_bits[0];
        if (pat_age == 63) begin
          pat_age = 0;
          case ($urandom_range(0, 3))
            0: stall_bits = '1;
            3: stall_bits = 16'($urandom) & 16'($urandom);
            default: stall_bits = 16'($urandom);
          endcase
        end else begin
          pat_age++;
          stall_bits = {stall_bits[0], stall_bits[15:1]};
        end
      end
    end
  end

  // sample checker
  always @(posedge clk) begin : sample_check
    logic [15:0] want;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      if (pending_samples.size() == 0) begin
        flag_failure($sformatf("unexpected sample word %h", sample_ch.sample));
      end else begin
        want = pending_samples.pop_front();
        if (sample_ch.sample !== want)
          flag_failure($sformatf("sample mismatch: expected %h, got %h",
                                 want, sample_ch.sample));
      end
    end
  end

  initial begin
    bit in_cfg;
    int phase;
    rst <= 1'b1;
    trig_ch.valid <= 1'b0;
    trig_ch.note_trigger <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= lfo_pkg::REG_PHASE_STEP;
    cfg_ch.data <= '0;

    // directed table
    row_word(1'b0, 1'b1, 16'h8000);
    row_word(1'b1, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_RETRIGGER, 30'd1);
    row_word(1'b1, 1'b1, 16'h8000);
    row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_PHASE_STEP, 30'h3fffffff);
    row_cfg(lfo_pkg::REG_WAVE_SELECT, 30'(lfo_pkg::SHAPE_NOISE));
    row_word(1'b1, 1'b1, 16'h7e00);
    repeat (3) row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_WAVE_SELECT, 30'd7);
    row_word(1'b1, 1'b1, 16'h7e00);
    row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_WAVE_SELECT, 30'(lfo_pkg::SHAPE_SQUARE));
    row_cfg(lfo_pkg::REG_PULSE_WIDTH, 30'd0);
    row_word(1'b1, 1'b1, 16'h7fff);
    row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_PULSE_WIDTH, 30'd65536);
    row_word(1'b1, 1'b1, 16'h8000);
    row_cfg(lfo_pkg::REG_PULSE_WIDTH, 30'h3fffffff);
    row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_WAVE_SELECT, 30'(lfo_pkg::SHAPE_TRIANGLE));
    row_cfg(lfo_pkg::REG_PHASE_STEP, 30'h0800_0000);
    row_word(1'b1, 1'b1, 16'h8000);
    repeat (4) row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_WAVE_SELECT, 30'h3ffffffb);
    row_word(1'b1, 1'b1, 16'h0000);
    repeat (3) row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_PHASE_STEP, 30'd1);
    row_word(1'b0, 1'b0, 16'h0000);
    row_cfg(lfo_pkg::REG_RETRIGGER, 30'h3ffffffe);
    row_word(1'b1, 1'b0, 16'h0000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    in_cfg = 1'b0;
    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        if (!in_cfg) begin
          drain();
          in_cfg = 1'b1;
        end
        write_reg(stim_table[i].reg_sel, stim_table[i].value);
      end else begin
        if (in_cfg) begin
          cfg_ch.valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_trigger(stim_table[i].trig, stim_table[i].known, stim_table[i].want);
      end
    end

    // random phases, each starting from an idle block
    phase = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      drain();
      random_setup();
      if (phase == 3) begin
        hold_req <= 1'b1;
        send_words(60, 1'b1);
      end else begin
        send_words($urandom_range(8, 60), $urandom_range(0, 4) == 0);
      end
      phase++;
    end

    drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
